// ===== rtl/core/salc_pkg.sv =====
`default_nettype none
package salc_pkg;

	localparam int LINES         = 512;
	localparam int LINE_W        = $clog2(LINES);
	localparam int MAX_WAYS      = 16;
	localparam int WAYS_LG_MAX   = $clog2(MAX_WAYS);
	localparam int OFFSET_BITS   = 5;
	localparam int AGE_BITS      = 16;
	localparam int ADDR_W        = 32;
	localparam int IDX_W         = ADDR_W - OFFSET_BITS;
	localparam int TAG_W         = IDX_W - (LINE_W - WAYS_LG_MAX);
	localparam int LANES         = MAX_WAYS;
	localparam int LANE_W        = $clog2(LANES);
	localparam int ROWS          = LINES / LANES;
	localparam int ROW_W         = $clog2(ROWS);
	localparam int CNT_W         = 32;

	localparam logic [0:0] REG_WAYS_LOG2     = 1'd0;
	localparam logic [0:0] REG_PREFETCH_MODE = 1'd1;

	localparam logic [1:0] MODE_NORMAL       = 2'd0;
	localparam logic [1:0] MODE_NO_WALLOC    = 2'd1;
	localparam logic [1:0] MODE_PF_ALWAYS    = 2'd2;
	localparam logic [1:0] MODE_PF_MISS      = 2'd3;

	// One memory row holds 16 consecutive lines, so any set fits in one row.
	typedef struct packed {
		logic [LANES-1:0]                v;
		logic [LANES-1:0][TAG_W-1:0]     tag;
		logic [LANES-1:0][AGE_BITS-1:0]  age;
	} row_t;

	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [LANE_W-1:0] off;
		logic [TAG_W-1:0]  tag;
	} loc_t;

	function automatic loc_t locate(input logic [IDX_W-1:0] idx, input logic [2:0] k);
		logic [3:0]        sb;
		logic [LINE_W-1:0] set_v;
		logic [LINE_W-1:0] base;
		logic [IDX_W-1:0]  sh;
		loc_t              r;
		sb    = 4'(LINE_W) - 4'(k);
		set_v = idx[LINE_W-1:0] & LINE_W'((LINE_W'(1) << sb) - LINE_W'(1));
		base  = set_v << k;
		sh    = idx >> sb;
		r.row = base[LINE_W-1:LANE_W];
		r.off = base[LANE_W-1:0];
		r.tag = sh[TAG_W-1:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/salc_if.sv =====
`default_nettype none
interface salc_req_if;
	logic                       valid;
	logic                       ready;
	logic [salc_pkg::ADDR_W-1:0] address;
	logic                       is_store;
	modport source (output valid, address, is_store, input ready);
	modport sink   (input valid, address, is_store, output ready);
endinterface

interface salc_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       hit;
	logic [salc_pkg::CNT_W-1:0] hit_count;
	logic [salc_pkg::CNT_W-1:0] access_count;
	modport source (output valid, hit, hit_count, access_count, input ready);
	modport sink   (input valid, hit, hit_count, access_count, output ready);
endinterface

interface salc_cfg_if;
	logic       valid;
	logic       ready;
	logic [0:0] index;
	logic [2:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/set_assoc_lru_cache_prefetch.sv =====
`default_nettype none
// Tag-only set-associative cache, 512 lines of 32 bytes, 1 to 16 ways, LRU by
// per-line 16-bit ages. One transaction in, at most one out (none for address
// zero). Line state lives in a 32-row memory, one row of 16 lines per entry.
// The first row is read in the accept cycle; each set touched is then
// modified and written back, and the prefetched set has a read state of its
// own. The result is queued from S_DONE after S_UPD_A, or after S_RD_B and
// S_UPD_B when the next line is prefetched, and the next transaction is
// accepted only after the result is queued, so one access is in flight at a
// time. A held result stalls the next access in its final state. A zero
// address is accepted and dropped without a result.
// A row never written reads as all lines invalid with age zero, so there is no
// clearing pass after reset. Changing ways_log2 does not flush the cache.
module set_assoc_lru_cache_prefetch (
	input  wire logic clk,
	input  wire logic arst_n,
	salc_req_if.sink  req,
	salc_rsp_if.source rsp,
	salc_cfg_if.sink  cfg
);
	import salc_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_UPD_A, S_RD_B, S_UPD_B, S_DONE} state_t;

	state_t            state_q;
	logic [2:0]        ways_lg_q;
	logic [1:0]        mode_q;
	logic [IDX_W-1:0]  idx_q;
	logic              store_q;
	logic              hit_q;
	logic [ROWS-1:0]   row_init_q;
	logic [CNT_W-1:0]  hits_q;
	logic [CNT_W-1:0]  acc_q;
	logic              rsp_valid_q;
	logic              rsp_hit_q;
	logic [CNT_W-1:0]  rsp_hits_q;
	logic [CNT_W-1:0]  rsp_acc_q;

	row_t              mem [ROWS];
	row_t              rdata_s1;
	logic [ROW_W-1:0]  rrow_s1;

	logic [2:0]        k;
	logic [LANE_W-1:0] wmask;
	logic [IDX_W-1:0]  req_idx;
	logic [IDX_W-1:0]  nidx;
	loc_t              loc_in;
	loc_t              loc_b;
	loc_t              loc_c;
	logic              rd_en;
	logic [ROW_W-1:0]  rd_row;
	logic              wr_en;
	logic              fill_req;
	logic              need_b;
	logic              rsp_load;

	row_t              cur;
	row_t              nxt;
	logic [LANES-1:0]  inset;
	logic [LANES-1:0]  match;
	logic              present;
	logic              free_any;
	logic [LANE_W-1:0] free_lane;
	logic [LANE_W-1:0] victim;
	logic [LANES-1:0][AGE_BITS-1:0] t_age;
	logic [LANES-1:0][LANE_W-1:0]   t_lane;
	logic [LANES-1:0]               t_en;

	assign k       = (ways_lg_q > 3'(WAYS_LG_MAX)) ? 3'(WAYS_LG_MAX) : ways_lg_q;
	assign wmask   = LANE_W'((LANE_W+1)'(1) << k) - LANE_W'(1);
	assign req_idx = req.address[ADDR_W-1:OFFSET_BITS];
	assign nidx    = idx_q + IDX_W'(1);
	assign loc_in  = locate(req_idx, k);
	assign loc_b   = locate(nidx, k);
	assign loc_c   = (state_q == S_UPD_B) ? loc_b : locate(idx_q, k);

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid        = rsp_valid_q;
	assign rsp.hit          = rsp_hit_q;
	assign rsp.hit_count    = rsp_hits_q;
	assign rsp.access_count = rsp_acc_q;

	assign rd_en  = (req.valid && state_q == S_IDLE) || state_q == S_RD_B;
	assign rd_row = (state_q == S_RD_B) ? loc_b.row : loc_in.row;
	assign wr_en  = (state_q == S_UPD_A) || (state_q == S_UPD_B);
	assign fill_req = (state_q == S_UPD_B) || !(mode_q == MODE_NO_WALLOC && store_q);
	assign need_b   = present ? (mode_q == MODE_PF_ALWAYS)
		: (mode_q == MODE_PF_ALWAYS || mode_q == MODE_PF_MISS);
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	// Set update: lookup, victim choice, fill and ageing over one row
	always_comb begin
		cur = row_init_q[rrow_s1] ? rdata_s1 : '0;
		for (int l = 0; l < LANES; l++) begin
			inset[l] = ((LANE_W'(l) ^ loc_c.off) & ~wmask) == '0;
			match[l] = inset[l] && cur.v[l] && cur.tag[l] == loc_c.tag;
		end
		present = |match;
		free_any = 1'b0;
		free_lane = '0;
		for (int l = LANES-1; l >= 0; l--) begin
			if (inset[l] && !cur.v[l]) begin
				free_any  = 1'b1;
				free_lane = LANE_W'(l);
			end
		end
		// oldest valid way, ties to the lowest, as a 4-level tree
		for (int l = 0; l < LANES; l++) begin
			t_age[l]  = cur.age[l];
			t_lane[l] = LANE_W'(l);
			t_en[l]   = inset[l];
		end
		for (int lv = 0; lv < LANE_W; lv++) begin
			for (int i = 0; i < (LANES >> (lv+1)); i++) begin
				if (t_en[2*i+1] && (!t_en[2*i] || t_age[2*i+1] > t_age[2*i])) begin
					t_age[i]  = t_age[2*i+1];
					t_lane[i] = t_lane[2*i+1];
					t_en[i]   = 1'b1;
				end else begin
					t_age[i]  = t_age[2*i];
					t_lane[i] = t_lane[2*i];
					t_en[i]   = t_en[2*i];
				end
			end
		end
		victim = free_any ? free_lane : t_lane[0];
		nxt = cur;
		if (!present && fill_req) begin
			nxt.v[victim]   = 1'b1;
			nxt.tag[victim] = loc_c.tag;
		end
		for (int l = 0; l < LANES; l++) begin
			if (inset[l]) begin
				if (nxt.v[l] && nxt.tag[l] == loc_c.tag)
					nxt.age[l] = '0;
				else if (nxt.age[l] != '1)
					nxt.age[l] = nxt.age[l] + AGE_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= mem[rd_row];
			rrow_s1  <= rd_row;
		end
		if (wr_en)
			mem[loc_c.row] <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ways_lg_q   <= 3'd1;
			mode_q      <= MODE_NORMAL;
			row_init_q  <= '0;
			hits_q      <= '0;
			acc_q       <= '0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_WAYS_LOG2:     ways_lg_q <= cfg.data;
					REG_PREFETCH_MODE: mode_q    <= cfg.data[1:0];
					default: ;
				endcase
			end
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
			if (wr_en)
				row_init_q[loc_c.row] <= 1'b1;
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						idx_q   <= req_idx;
						store_q <= req.is_store;
						if (req.address != '0)
							state_q <= S_UPD_A;
					end
				end
				S_UPD_A: begin
					hit_q   <= present;
					state_q <= need_b ? S_RD_B : S_DONE;
				end
				S_RD_B:  state_q <= S_UPD_B;
				S_UPD_B: state_q <= S_DONE;
				S_DONE: begin
					if (rsp_load) begin
						rsp_hit_q   <= hit_q;
						rsp_hits_q  <= (hit_q && hits_q != '1) ? hits_q + CNT_W'(1) : hits_q;
						rsp_acc_q   <= (acc_q != '1) ? acc_q + CNT_W'(1) : acc_q;
						if (hit_q && hits_q != '1)
							hits_q <= hits_q + CNT_W'(1);
						if (acc_q != '1)
							acc_q <= acc_q + CNT_W'(1);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
